// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers for the circle shader RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ----- rtl/cfsps_pkg.sv -----
// ---------------------------------------------------------------------------
// Circle shader package
// Register widths, register indexes, region codes and the color blend.
// ---------------------------------------------------------------------------
package cfsps_pkg;

    localparam int CENTER_W  = 14;
    localparam int RADIUS_W  = 12;
    localparam int STROKE_W  = 8;
    localparam int COLOR_W   = 24;
    localparam int OPACITY_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int RSQ_W     = 2 * RADIUS_W;
    localparam int OUTER_W   = RADIUS_W + 1;
    localparam int OSQ_W     = 2 * OUTER_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CTR_COL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTR_ROW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_RGB   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_RGB   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY    = 3'd6;

    localparam logic [1:0] REGION_NONE   = 2'd0;
    localparam logic [1:0] REGION_FILL   = 2'd1;
    localparam logic [1:0] REGION_STROKE = 2'd2;

    localparam logic [OPACITY_W-1:0] OPACITY_FULL = 9'd256;
    localparam logic [7:0]           CH_MAX       = 8'hFF;

    typedef struct packed {
        logic signed [CENTER_W-1:0] ctr_col;
        logic signed [CENTER_W-1:0] ctr_row;
        logic [RADIUS_W-1:0]        radius;
        logic [STROKE_W-1:0]        ring_width;
        logic [COLOR_W-1:0]         fill_rgb;
        logic [COLOR_W-1:0]         ring_rgb;
        logic [OPACITY_W-1:0]       opacity;
    } cfg_t;

    // Classified pixel: region code and the raw color picked for it.
    typedef struct packed {
        logic [1:0]         region;
        logic [COLOR_W-1:0] color;
    } class_t;

    // Truncating blend of one 8-bit channel toward white, op below 256.
    function automatic logic [7:0] blend_chan(input logic [7:0] c, input logic [7:0] op);
        logic [8:0]  inv;
        logic [16:0] sum;
        inv = OPACITY_FULL - {1'b0, op};
        sum = 17'(CH_MAX) * 17'(inv) + 17'(c) * 17'(op);
        return sum[15:8];
    endfunction

endpackage

// ----- rtl/circle_fill_stroke_pixel_shader.sv -----
// Throughput: one pixel per cycle while out_stall is low; four register stages
// (offsets, squares, distance compare, color blend) each hold one word, and a
// stage advances when it is empty or the next one advances.
// Reset clears all stage valid bits and sets the registers to their defaults:
// center, radius, stroke and colors zero, opacity fully opaque (256).
// ---------------------------------------------------------------------------
// Circle fill and stroke pixel shader
// Classifies each pixel against a circle and its ring and returns its color.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module circle_fill_stroke_pixel_shader
    import cfsps_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COLOR_W-1:0]    cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            region,
    output logic                  paint,
    output logic [COLOR_W-1:0]    pixel_color
);

    cfg_t   cfg_reg;
    logic   cls_valid;
    logic   cls_stall;
    class_t cls;
    logic   out_blank;
    logic   out_ring;
    logic   opaque_fill;
    logic   ring_on;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{ctr_col: '0, ctr_row: '0, radius: '0, ring_width: '0,
                         fill_rgb: '0, ring_rgb: '0, opacity: OPACITY_FULL};
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CTR_COL:    cfg_reg.ctr_col    <= $signed(cfg_data[CENTER_W-1:0]);
                CFG_CTR_ROW:    cfg_reg.ctr_row    <= $signed(cfg_data[CENTER_W-1:0]);
                CFG_RADIUS:     cfg_reg.radius     <= cfg_data[RADIUS_W-1:0];
                CFG_RING_WIDTH: cfg_reg.ring_width <= cfg_data[STROKE_W-1:0];
                CFG_FILL_RGB:   cfg_reg.fill_rgb   <= cfg_data;
                CFG_RING_RGB:   cfg_reg.ring_rgb   <= cfg_data;
                CFG_OPACITY:    cfg_reg.opacity    <= cfg_data[OPACITY_W-1:0];
                default:        ;
            endcase
        end
    end

    cfsps_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .cls_valid (cls_valid),
        .cls_stall (cls_stall),
        .cls       (cls)
    );

    cfsps_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cls_valid   (cls_valid),
        .cls_stall   (cls_stall),
        .cls         (cls),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .region      (region),
        .pixel_color (pixel_color)
    );

    assign paint = (region != REGION_NONE);

    assign out_blank   = out_valid && (region == REGION_NONE);
    assign out_ring    = out_valid && (region == REGION_STROKE);
    assign opaque_fill = out_valid && (region == REGION_FILL) && cfg_reg.opacity[OPACITY_W-1];
    assign ring_on     = (cfg_reg.ring_width != '0) && (cfg_reg.ring_rgb != '0);

    `ASSERT_CLK(a_blank_color, out_blank |-> (pixel_color == '0), "untouched word has a color")
    `ASSERT_CLK(a_ring_enabled, out_ring |-> ring_on, "ring word while ring is off")
    `ASSERT_CLK(a_opaque, opaque_fill |-> (pixel_color == cfg_reg.fill_rgb), "opaque fill altered")

endmodule

// ----- rtl/cfsps_geom.sv -----
// ---------------------------------------------------------------------------
// Circle shader geometry stages
// Three register stages: offsets, squares, then distance compare and region.
// ---------------------------------------------------------------------------
module cfsps_geom
    import cfsps_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    output logic                  cls_valid,
    input  logic                  cls_stall,
    output class_t                cls
);

    localparam int DX_W = ((COORD_BITS + 1 > CENTER_W) ? COORD_BITS + 1 : CENTER_W) + 1;
    localparam int AB_W = DX_W - 1;
    localparam int SQ_W = 2 * AB_W;
    localparam int D2_W = SQ_W + 1;

    logic adv1, adv2, adv3;
    logic v1_reg, v2_reg, v3_reg;

    logic signed [DX_W-1:0] dx, dy;
    logic [OUTER_W-1:0]     outer;
    logic [AB_W-1:0]        ax_reg, ay_reg;
    logic [RSQ_W-1:0]       rsq1_reg, rsq2_reg;
    logic [OSQ_W-1:0]       osq1_reg, osq2_reg;
    logic [SQ_W-1:0]        sqx_reg, sqy_reg;
    logic [D2_W-1:0]        d2;
    logic                   stroke_on;
    class_t                 cls_next, cls_reg;

    // Each stage moves when its register is empty or the next one moves.
    assign adv3     = !v3_reg || !cls_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_comb
    begin
        dx = $signed({{(DX_W - COORD_BITS){1'b0}}, pixel_x})
           - $signed({{(DX_W - CENTER_W){cfg.ctr_col[CENTER_W-1]}}, cfg.ctr_col});
        dy = $signed({{(DX_W - COORD_BITS){1'b0}}, pixel_y})
           - $signed({{(DX_W - CENTER_W){cfg.ctr_row[CENTER_W-1]}}, cfg.ctr_row});
        outer = {1'b0, cfg.radius} + OUTER_W'(cfg.ring_width);
    end

    always_comb
    begin
        d2        = D2_W'(sqx_reg) + D2_W'(sqy_reg);
        stroke_on = (cfg.ring_width != '0) && (cfg.ring_rgb != '0);
        cls_next  = '{region: REGION_NONE, color: '0};
        if (d2 <= D2_W'(rsq2_reg))
        begin
            cls_next = '{region: REGION_FILL, color: cfg.fill_rgb};
        end
        else if (stroke_on && d2 <= D2_W'(osq2_reg))
        begin
            cls_next = '{region: REGION_STROKE, color: cfg.ring_rgb};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            ax_reg   <= dx[DX_W-1] ? AB_W'(-dx) : AB_W'(dx);
            ay_reg   <= dy[DX_W-1] ? AB_W'(-dy) : AB_W'(dy);
            rsq1_reg <= RSQ_W'(cfg.radius) * RSQ_W'(cfg.radius);
            osq1_reg <= OSQ_W'(outer) * OSQ_W'(outer);
        end
        if (adv2 && v1_reg)
        begin
            sqx_reg  <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sqy_reg  <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
            rsq2_reg <= rsq1_reg;
            osq2_reg <= osq1_reg;
        end
        if (adv3 && v2_reg)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = v3_reg;
    assign cls       = cls_reg;

endmodule

// ----- rtl/cfsps_blend.sv -----
// ---------------------------------------------------------------------------
// Circle shader blend stage
// Blends the chosen color toward white by opacity into the output register.
// ---------------------------------------------------------------------------
module cfsps_blend
    import cfsps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               cls_valid,
    output logic               cls_stall,
    input  class_t             cls,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         region,
    output logic [COLOR_W-1:0] pixel_color
);

    logic               adv;
    logic               v_reg;
    logic [COLOR_W-1:0] color_next, color_reg;
    logic [1:0]         region_reg;

    assign adv       = !v_reg || !out_stall;
    assign cls_stall = !adv;

    always_comb
    begin
        if (cls.region == REGION_NONE)
        begin
            color_next = '0;
        end
        else if (cfg.opacity[OPACITY_W-1])
        begin
            // Opacity of 256 or more passes the color as it is.
            color_next = cls.color;
        end
        else
        begin
            color_next = {blend_chan(cls.color[23:16], cfg.opacity[7:0]),
                          blend_chan(cls.color[15:8],  cfg.opacity[7:0]),
                          blend_chan(cls.color[7:0],   cfg.opacity[7:0])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= cls_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && cls_valid)
        begin
            region_reg <= cls.region;
            color_reg  <= color_next;
        end
    end

    assign out_valid   = v_reg;
    assign region      = region_reg;
    assign pixel_color = color_reg;

endmodule
